>>> hw/rtl/spq_pkg.sv
package spq_pkg;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef enum logic {
    ReqInsert = 1'b0,
    ReqRemove = 1'b1
  } req_type_e;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } rsp_t;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SShift,
    SWrite,
    SFinish,
    SOut
  } state_e;

endpackage

>>> hw/rtl/spq_mem.sv
module spq_mem #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [63:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [63:0]      rdata_o
);

  logic [63:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hw/rtl/sorted_priority_queue.sv
// Sorted priority queue of up to CAPACITY entries held in one synchronous
// memory, highest priority at address 0. Every request returns one response
// with status, removed value, count, front and back values. A remove from
// an empty queue and an insert into a full one go straight to SOut; any
// other remove passes through SFinish. An insert may scan for its position
// (SScan) and shift the lower entries down (SShift) before SWrite; the scan
// and the shift each move one entry per cycle through the memory's one read
// and one write port. The response is held in SOut while out_stall_i is
// high. The front and back values are tracked in registers; one request is
// worked on at a time.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spq_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spq_pkg::rsp_t out_data_o
);
  import spq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;
  req_t   req_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] idx_q, idx_d;
  logic signed [31:0] front_q, front_d, back_q, back_d;
  logic signed [31:0] fprio_q, fprio_d;
  rsp_t rsp_q, rsp_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  spq_mem #(.Depth(CAPACITY), .AddrW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic signed [31:0] rd_val, rd_pri;
  assign rd_val = rdata[63:32];
  assign rd_pri = rdata[31:0];

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_data_o  = rsp_q;

  // Shift reads entry idx_q-1 and scan reads entry pos_q, the data returning in state SShift/SScan.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    front_d = front_q;
    back_d  = back_q;
    fprio_d = fprio_q;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = idx_q[AW-1:0];
    wdata   = rdata;
    raddr   = idx_q[AW-1:0];
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          rsp_d = '0;
          if (in_data_i.req_type == ReqRemove) begin
            if (cnt_q == '0) begin
              rsp_d.status = StEmpty;
              state_d = SOut;
            end else begin
              rsp_d.removed_value = back_q;
              cnt_d = cnt_q - 1'b1;
              idx_d = cnt_q - CW'(2);
              raddr = AW'(cnt_q - CW'(2));
              state_d = SFinish;
            end
          end else if (cnt_q == CW'(CAPACITY)) begin
            rsp_d.status = StFull;
            rsp_d.entry_count = 5'(cnt_q);
            rsp_d.front_value = front_q;
            rsp_d.back_value  = back_q;
            state_d = SOut;
          end else if (cnt_q == '0 || in_data_i.item_priority > fprio_q) begin
            pos_d = '0;
            idx_d = cnt_q;
            state_d = (cnt_q == '0) ? SWrite : SShift;
            raddr = AW'(cnt_q - 1'b1);
          end else begin
            pos_d = CW'(1);
            raddr = AW'(1);
            state_d = SScan;
          end
        end
      end
      SScan: begin
        // rdata holds entry pos_q when pos_q < cnt_q
        if (pos_q < cnt_q && rd_pri > req_q.item_priority) begin
          pos_d = pos_q + 1'b1;
          raddr = AW'(pos_q + 1'b1);
        end else begin
          idx_d = cnt_q;
          raddr = AW'(cnt_q - 1'b1);
          state_d = (pos_q == cnt_q) ? SWrite : SShift;
        end
      end
      SShift: begin
        // rdata holds entry idx_q-1; move it to idx_q
        we    = 1'b1;
        waddr = idx_q[AW-1:0];
        wdata = rdata;
        if (idx_q == cnt_q) back_d = rd_val;
        idx_d = idx_q - 1'b1;
        raddr = AW'(idx_q - CW'(2));
        if (idx_q - 1'b1 == pos_q) state_d = SWrite;
      end
      SWrite: begin
        we    = 1'b1;
        waddr = pos_q[AW-1:0];
        wdata = {req_q.item_value, req_q.item_priority};
        if (pos_q == '0) begin
          front_d = req_q.item_value;
          fprio_d = req_q.item_priority;
        end
        if (pos_q == cnt_q) back_d = req_q.item_value;
        cnt_d = cnt_q + 1'b1;
        rsp_d.entry_count = 5'(cnt_q + 1'b1);
        rsp_d.front_value = (pos_q == '0) ? req_q.item_value : front_q;
        rsp_d.back_value  = (pos_q == cnt_q) ? req_q.item_value :
                            ((idx_q == cnt_q) ? back_q : back_d);
        state_d = SOut;
      end
      SFinish: begin
        // rdata holds new back entry (address cnt_q-1) if any
        rsp_d.entry_count = 5'(cnt_q);
        if (cnt_q == '0) begin
          front_d = '0;
          back_d  = '0;
        end else begin
          back_d = rd_val;
        end
        rsp_d.front_value = (cnt_q == '0) ? '0 : front_q;
        rsp_d.back_value  = (cnt_q == '0) ? '0 : rd_val;
        state_d = SOut;
      end
      SOut: begin
        if (!out_stall_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) req_q <= in_data_i;
    pos_q   <= pos_d;
    idx_q   <= idx_d;
    front_q <= front_d;
    back_q  <= back_d;
    fprio_q <= fprio_d;
    rsp_q   <= rsp_d;
  end

endmodule

>>> verif/spq_checker.sv
`timescale 1ns / 100ps

module spq_checker #(
  parameter int CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  spq_pkg::req_t in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  spq_pkg::rsp_t out_data_i,
  output int            fail_count_o,
  output int            pending_o
);
  import spq_pkg::*;

  logic signed [31:0] model_values[CAPACITY];
  logic signed [31:0] model_prios[CAPACITY];
  int                 model_count;
  rsp_t               expected_rsps[$];

  function automatic rsp_t apply_request(req_t req);
    rsp_t rsp;
    int pos;
    rsp = '0;
    rsp.status = StDone;
    if (req.req_type == ReqInsert) begin
      if (model_count >= CAPACITY) begin
        rsp.status = StFull;
      end else begin
        if (model_count == 0 || req.item_priority > model_prios[0]) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < model_count && model_prios[pos] > req.item_priority) pos++;
        end
        for (int i = model_count; i > pos; i--) begin
          model_values[i] = model_values[i-1];
          model_prios[i] = model_prios[i-1];
        end
        model_values[pos] = req.item_value;
        model_prios[pos] = req.item_priority;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        rsp.status = StEmpty;
      end else begin
        model_count--;
        rsp.removed_value = model_values[model_count];
      end
    end
    rsp.entry_count = model_count[4:0];
    rsp.front_value = model_count > 0 ? model_values[0] : '0;
    rsp.back_value = model_count > 0 ? model_values[model_count-1] : '0;
    return rsp;
  endfunction

  assign pending_o = expected_rsps.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    int   errs;
    errs = 0;
    if (!rst_ni) begin
      model_count = 0;
      fail_count_o <= 0;
      expected_rsps.delete();
    end else begin
      if (in_valid_i && !in_stall_i) expected_rsps.push_back(apply_request(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response %p", out_data_i);
          errs++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_data_i.status !== exp_rsp.status) begin
            $error("status: expected %0d actual %0d", exp_rsp.status, out_data_i.status);
            errs++;
          end
          if (out_data_i.removed_value !== exp_rsp.removed_value) begin
            $error("removed_value: expected %0d actual %0d",
                   exp_rsp.removed_value, out_data_i.removed_value);
            errs++;
          end
          if (out_data_i.entry_count !== exp_rsp.entry_count) begin
            $error("entry_count: expected %0d actual %0d",
                   exp_rsp.entry_count, out_data_i.entry_count);
            errs++;
          end
          if (out_data_i.front_value !== exp_rsp.front_value) begin
            $error("front_value: expected %0d actual %0d",
                   exp_rsp.front_value, out_data_i.front_value);
            errs++;
          end
          if (out_data_i.back_value !== exp_rsp.back_value) begin
            $error("back_value: expected %0d actual %0d",
                   exp_rsp.back_value, out_data_i.back_value);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

>>> verif/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int NUM_RANDOM = 830;
  localparam int WATCHDOG_LIMIT = 4000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  req_t  in_data_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  rsp_t  out_data_o;
  int    fail_count;
  int    pending;
  bit    quiet_phase = 1'b0;
  int    idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  sorted_priority_queue #(.CAPACITY(CAPACITY)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  spq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7);
      3: return -$urandom_range(1, 7);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(req_type_e kind, logic [31:0] value, logic [31:0] prio);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{req_type: kind, item_value: value, item_priority: prio};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int fill;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_request(ReqRemove, 32'h1234_5678, 32'h0);
    send_request(ReqInsert, 32'h7fff_ffff, 32'h0);
    send_request(ReqRemove, 32'h0, 32'h0);
    send_request(ReqInsert, 32'h8000_0000, 32'h8000_0000);
    send_request(ReqInsert, 32'd5, 32'h7fff_ffff);
    send_request(ReqInsert, 32'd6, 32'h7fff_ffff);
    send_request(ReqInsert, 32'd7, 32'd0);
    send_request(ReqInsert, 32'd8, 32'd0);
    send_request(ReqInsert, 32'hffff_ffff, 32'h8000_0000);
    for (int i = 0; i < 9; i++) send_request(ReqInsert, i + 100, 32'd3);
    send_request(ReqInsert, 32'd999, 32'd3);
    send_request(ReqInsert, 32'd998, 32'h7fff_ffff);
    for (int i = 0; i < 17; i++) send_request(ReqRemove, 32'hffff_ffff, 32'hffff_ffff);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    fill = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - 150) quiet_phase = 1'b1;
      if (n % 60 == 0) fill = $urandom_range(0, 3);
      if ($urandom_range(0, 3) < fill + 1)
        send_request(ReqInsert, rand_word(), rand_word());
      else
        send_request(ReqRemove, rand_word(), rand_word());
    end
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (60) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_mem.sv
hw/rtl/sorted_priority_queue.sv
verif/spq_checker.sv
verif/tb_sorted_priority_queue.sv
